FILE: hw/rtl/kmd_pkg.sv
// kmd_pkg: shared types and constants of the key matrix debouncer
// no dependencies; used by the interfaces, the cells, the register block and the top level
package kmd_pkg;

    // sizes
    localparam int KEY_TOTAL   = 16;
    localparam int RAW_WIDTH   = 16;
    localparam int TIME_WIDTH  = 32;
    localparam int DEB_WIDTH   = 16;
    localparam int KEY_WIDTH   = 8;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    // item commands
    localparam logic CMD_SCAN  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // register map (word index taken from paddr[2])
    localparam logic REG_DEBOUNCE = 1'b0;
    localparam logic [DEB_WIDTH-1:0] DEBOUNCE_RESET = DEB_WIDTH'(20);

    // key number that a cell answers to; it is decremented once per cell
    localparam logic [KEY_WIDTH-1:0] KEY_HERE = KEY_WIDTH'(1);

    typedef struct packed {
        logic key_valid;
        logic key_down;
        logic pressed_seen;
        logic released_seen;
    } kmd_result_t;

    // item as it travels along the cell chain
    typedef struct packed {
        logic                  command;
        logic [RAW_WIDTH-1:0]  raw_keys;
        logic [TIME_WIDTH-1:0] time_ms;
        logic [KEY_WIDTH-1:0]  key_number;
        logic                  clear_pressed;
        logic                  clear_released;
        kmd_result_t           result;
    } kmd_token_t;

endpackage

FILE: hw/rtl/kmd_ifs.sv
// kmd_scan_if and kmd_result_if: valid/ready channels of the debouncer
// depends on kmd_pkg for field widths

interface kmd_scan_if;
    logic                            valid;
    logic                            ready;
    logic                            command;
    logic [kmd_pkg::RAW_WIDTH-1:0]   raw_keys;
    logic [kmd_pkg::TIME_WIDTH-1:0]  time_ms;
    logic [kmd_pkg::KEY_WIDTH-1:0]   key_number;
    logic                            clear_pressed;
    logic                            clear_released;

    modport source (
        output valid, command, raw_keys, time_ms, key_number, clear_pressed, clear_released,
        input  ready
    );
    modport sink (
        input  valid, command, raw_keys, time_ms, key_number, clear_pressed, clear_released,
        output ready
    );
endinterface

interface kmd_result_if;
    logic valid;
    logic ready;
    logic key_valid;
    logic key_down;
    logic pressed_seen;
    logic released_seen;

    modport source (
        output valid, key_valid, key_down, pressed_seen, released_seen,
        input  ready
    );
    modport sink (
        input  valid, key_valid, key_down, pressed_seen, released_seen,
        output ready
    );
endinterface

FILE: hw/rtl/kmd_regs.sv
// kmd_regs: APB-style configuration register holding the debounce time
// depends on kmd_pkg for the register map and reset value
module kmd_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [kmd_pkg::APB_AW-1:0]     paddr,
    input  logic [kmd_pkg::APB_DW-1:0]     pwdata,
    output logic [kmd_pkg::APB_DW-1:0]     prdata,
    output logic                           pready,
    output logic [kmd_pkg::DEB_WIDTH-1:0]  hold_time_ms
);

    logic [kmd_pkg::DEB_WIDTH-1:0] debounce_reg;
    logic [kmd_pkg::DEB_WIDTH-1:0] debounce_next;
    logic                          wr_hit;

    // write decode on the access phase
    always_comb
    begin
        wr_hit        = psel && penable && pwrite && (paddr[2] == kmd_pkg::REG_DEBOUNCE);
        debounce_next = wr_hit ? pwdata[kmd_pkg::DEB_WIDTH-1:0] : debounce_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= kmd_pkg::DEBOUNCE_RESET;
        end
        else
        begin
            debounce_reg <= debounce_next;
        end
    end

    // read mux
    always_comb
    begin
        case (paddr[2])
            kmd_pkg::REG_DEBOUNCE: prdata = kmd_pkg::APB_DW'(debounce_reg);
            default:               prdata = '0;
        endcase
    end

    assign pready       = 1'b1;
    assign hold_time_ms = debounce_reg;

endmodule

FILE: hw/rtl/kmd_cell.sv
// kmd_cell: one key's debounce state; applies each passing item and hands it on
// depends on kmd_pkg for the token type and command codes
module kmd_cell (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           advance,
    input  logic [kmd_pkg::DEB_WIDTH-1:0]  hold_time_ms,
    input  logic                           valid_in,
    input  kmd_pkg::kmd_token_t            token_in,
    output logic                           valid_out,
    output kmd_pkg::kmd_token_t            token_out
);

    logic                            raw_level_reg,  raw_level_next;
    logic                            stable_reg,     stable_next;
    logic                            press_reg,      press_next;
    logic                            release_reg,    release_next;
    logic [kmd_pkg::TIME_WIDTH-1:0]  change_time_reg, change_time_next;
    logic                            valid_out_reg;
    kmd_pkg::kmd_token_t             token_out_reg,  token_next;
    logic                            sample;
    logic [kmd_pkg::TIME_WIDTH-1:0]  elapsed;

    // update this key and build the item for the next cell
    always_comb
    begin
        raw_level_next   = raw_level_reg;
        stable_next      = stable_reg;
        press_next       = press_reg;
        release_next     = release_reg;
        change_time_next = change_time_reg;

        sample  = token_in.raw_keys[0];
        elapsed = token_in.time_ms - change_time_reg;

        // next cell sees its own raw bit at position 0 and its key one step closer
        token_next          = token_in;
        token_next.raw_keys = token_in.raw_keys >> 1;
        if (token_in.key_number != '0)
        begin
            token_next.key_number = token_in.key_number - kmd_pkg::KEY_HERE;
        end

        if (valid_in)
        begin
            case (token_in.command)
                kmd_pkg::CMD_SCAN:
                begin
                    if (sample != raw_level_reg)
                    begin
                        // raw change restarts the timer
                        raw_level_next   = sample;
                        change_time_next = token_in.time_ms;
                    end
                    else if ((raw_level_reg != stable_reg) &&
                             (elapsed >= kmd_pkg::TIME_WIDTH'(hold_time_ms)))
                    begin
                        stable_next = raw_level_reg;
                        if (raw_level_reg)
                        begin
                            press_next = 1'b1;
                        end
                        else
                        begin
                            release_next = 1'b1;
                        end
                    end
                end
                kmd_pkg::CMD_QUERY:
                begin
                    if (token_in.key_number == kmd_pkg::KEY_HERE)
                    begin
                        // report before clearing
                        token_next.result.key_valid     = 1'b1;
                        token_next.result.key_down      = stable_reg;
                        token_next.result.pressed_seen  = press_reg;
                        token_next.result.released_seen = release_reg;
                        if (token_in.clear_pressed)
                        begin
                            press_next = 1'b0;
                        end
                        if (token_in.clear_released)
                        begin
                            release_next = 1'b0;
                        end
                    end
                end
                default:
                begin
                    raw_level_next = raw_level_reg;
                end
            endcase
        end
    end

    // key state and chain valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_level_reg   <= 1'b0;
            stable_reg      <= 1'b0;
            press_reg       <= 1'b0;
            release_reg     <= 1'b0;
            change_time_reg <= '0;
            valid_out_reg   <= 1'b0;
        end
        else if (advance)
        begin
            raw_level_reg   <= raw_level_next;
            stable_reg      <= stable_next;
            press_reg       <= press_next;
            release_reg     <= release_next;
            change_time_reg <= change_time_next;
            valid_out_reg   <= valid_in;
        end
    end

    // item payload to the neighbor
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            token_out_reg <= token_next;
        end
    end

    assign valid_out = valid_out_reg;
    assign token_out = token_out_reg;

endmodule

FILE: hw/rtl/key_matrix_debouncer.sv
// key_matrix_debouncer: top level, chain of per-key cells, output register, config port
// depends on kmd_pkg, kmd_ifs (kmd_scan_if, kmd_result_if), kmd_regs and kmd_cell

// Per-key debouncer for a scanned key matrix. Every item walks a chain of
// KEY_TOTAL cells, one cell per key and one cell per cycle while the chain
// advances, so scans and queries are applied to each key in arrival order.
// One item is accepted per clock unless a stalled result holds the chain; a
// query's result passes through the chain and then the output register,
// and scans produce no result. A stalled result holds the whole chain. The
// debounce time is programmed at byte address 0 and must only change while
// no item is in the chain.
module key_matrix_debouncer (
    input  logic                          clk,
    input  logic                          rst_n,
    kmd_scan_if.sink                      scan_item,
    kmd_result_if.source                  key_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [kmd_pkg::APB_AW-1:0]    paddr,
    input  logic [kmd_pkg::APB_DW-1:0]    pwdata,
    output logic [kmd_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);

    logic [kmd_pkg::DEB_WIDTH-1:0] hold_time_ms;
    logic                          advance;
    logic [kmd_pkg::KEY_TOTAL:0]   chain_valid;
    kmd_pkg::kmd_token_t           chain_token [kmd_pkg::KEY_TOTAL+1];
    logic                          out_valid_reg;
    kmd_pkg::kmd_result_t          out_result_reg;

    // configuration
    kmd_regs u_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .hold_time_ms (hold_time_ms)
    );

    // chain moves whenever the output slot is free or being emptied
    assign advance         = !out_valid_reg || key_result.ready;
    assign scan_item.ready = advance;

    // head of the chain
    always_comb
    begin
        chain_valid[0]                = scan_item.valid;
        chain_token[0].command        = scan_item.command;
        chain_token[0].raw_keys       = scan_item.raw_keys;
        chain_token[0].time_ms        = scan_item.time_ms;
        chain_token[0].key_number     = scan_item.key_number;
        chain_token[0].clear_pressed  = scan_item.clear_pressed;
        chain_token[0].clear_released = scan_item.clear_released;
        chain_token[0].result         = '0;
    end

    // one cell per key
    for (genvar k = 0; k < kmd_pkg::KEY_TOTAL; k++)
    begin : g_cell
        kmd_cell u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .advance      (advance),
            .hold_time_ms (hold_time_ms),
            .valid_in     (chain_valid[k]),
            .token_in     (chain_token[k]),
            .valid_out    (chain_valid[k+1]),
            .token_out    (chain_token[k+1])
        );
    end

    // output register, queries only
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= chain_valid[kmd_pkg::KEY_TOTAL] &&
                (chain_token[kmd_pkg::KEY_TOTAL].command == kmd_pkg::CMD_QUERY);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_result_reg <= chain_token[kmd_pkg::KEY_TOTAL].result;
        end
    end

    assign key_result.valid         = out_valid_reg;
    assign key_result.key_valid     = out_result_reg.key_valid;
    assign key_result.key_down      = out_result_reg.key_down;
    assign key_result.pressed_seen  = out_result_reg.pressed_seen;
    assign key_result.released_seen = out_result_reg.released_seen;

endmodule
